// ===== rtl/vn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Package for the vector normalize unit: widths, side-band word type,
// and the square-root and divider step functions. No dependencies.
package vn_pkg;

    localparam int COMP_W  = 32;
    localparam int SQ_W    = 64;
    localparam int SUM_W   = 65;
    localparam int LEN_W   = 33;
    localparam int QUO_W   = 31;
    localparam int ROOT_W  = 32;
    localparam int REM_W   = 34;
    localparam int DREM_W  = 33;
    localparam int NUM_SQ  = 32;   // one root bit per stage
    localparam int NUM_DV  = 31;   // one quotient bit per stage

    typedef struct packed {
        logic [3:0][COMP_W-1:0] mag;
        logic [3:0]             neg;
        logic                   zero;
    } side_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_st_t;

    // one restoring square-root digit
    function automatic sqrt_st_t sqrt_step(input sqrt_st_t s, input logic [1:0] pair);
        logic [REM_W+1:0] rem_sh;
        logic [REM_W+1:0] trial;
        sqrt_st_t         r;
        rem_sh = {s.rem, pair};
        trial  = {2'b00, s.root, 2'b01};
        if (rem_sh >= trial)
        begin
            r.rem  = REM_W'(rem_sh - trial);
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = REM_W'(rem_sh);
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // one restoring divider digit: returns {qbit, new remainder}
    function automatic logic [DREM_W:0] div_step(input logic [DREM_W-1:0] rem,
                                                 input logic nbit,
                                                 input logic [LEN_W-1:0] den);
        logic [DREM_W:0] rem_sh;
        logic [DREM_W:0] r;
        rem_sh = {rem, nbit};
        if (rem_sh >= {1'b0, den})
            r = {1'b1, DREM_W'(rem_sh - {1'b0, den})};
        else
            r = {1'b0, DREM_W'(rem_sh)};
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/vector_normalize_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Vector normalize unit: Q16.16 vector in, Q2.30 unit vector and length out.
// Depends on vn_pkg.
//
// Usage:
//  - Input channel in_valid/in_ready carries one word: comp_x..comp_w.
//  - Output channel out_valid/out_ready carries unit_x..unit_w, length,
//    was_zero.
//  - Config channel cfg_valid/cfg_ready/cfg_data writes use_fourth (bit 0).
//    Always ready; write only while the unit is empty.
//  - Throughput: one word per cycle while the output is not stalled.
//    Pipeline: 68 register stages; the accepting edge loads the first.
//    Stages: input, square, two adder stages, 32 square-root stages (one
//    root bit each), 31 divider stages (one quotient bit each, four lanes
//    side by side) and the output stage.
//  - Stall: the whole pipe holds when the output word is not taken;
//    in_ready drops at the same time, so nothing is lost or repeated.
//  - Reset clears all valid bits and sets use_fourth to 1.
//  - A zero vector gives zero units, zero length and was_zero set.
//  - Three-component mode: comp_w is ignored and unit_w is zero.
module vector_normalize_unit
    import vn_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] comp_x,
    input  wire logic signed [31:0] comp_y,
    input  wire logic signed [31:0] comp_z,
    input  wire logic signed [31:0] comp_w,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      unit_x,
    output logic signed [31:0]      unit_y,
    output logic signed [31:0]      unit_z,
    output logic signed [31:0]      unit_w,
    output logic [32:0]             length,
    output logic                    was_zero,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_data
);

    localparam int NSTG = 4 + NUM_SQ + NUM_DV + 1;

    logic              use_fourth_reg;
    logic [NSTG-1:0]   vld_reg;
    logic              en;

    // front stages
    logic [3:0][COMP_W-1:0] c_reg;
    logic                   u4_reg;
    side_t                  sd1_reg, sd2_reg, sd3_reg;
    logic [3:0][SQ_W-1:0]   sq_reg;
    logic [SUM_W-1:0]       s01_reg, s23_reg, sum_reg;

    // square-root chain
    sqrt_st_t               sq_st_reg  [NUM_SQ];
    logic [SQ_W-1:0]        sq_rad_reg [NUM_SQ];
    logic                   sq_top_reg [NUM_SQ];
    side_t                  sq_sd_reg  [NUM_SQ];

    // divider chain
    logic [3:0][DREM_W-1:0] dv_rem_reg [NUM_DV];
    logic [3:0][QUO_W-1:0]  dv_q_reg   [NUM_DV];
    logic [LEN_W-1:0]       dv_den_reg [NUM_DV];
    side_t                  dv_sd_reg  [NUM_DV];

    // output
    logic [3:0][31:0]       u_reg;
    logic [LEN_W-1:0]       len_reg;
    logic                   zero_reg;

    side_t                  sd1_next;
    logic [LEN_W-1:0]       len_next;

    assign en        = !vld_reg[NSTG-1] || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;
    assign out_valid = vld_reg[NSTG-1];
    assign unit_x    = u_reg[0];
    assign unit_y    = u_reg[1];
    assign unit_z    = u_reg[2];
    assign unit_w    = u_reg[3];
    assign length    = len_reg;
    assign was_zero  = zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            use_fourth_reg <= 1'b1;
        else if (cfg_valid && cfg_ready)
            use_fourth_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
    end

    // magnitudes, signs, zero test; unused w lane is forced to zero
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (i == 3 && !u4_reg)
            begin
                sd1_next.mag[i] = '0;
                sd1_next.neg[i] = 1'b0;
            end
            else
            begin
                sd1_next.mag[i] = c_reg[i][31] ? COMP_W'(-c_reg[i]) : c_reg[i];
                sd1_next.neg[i] = c_reg[i][31];
            end
        end
        sd1_next.zero = (sd1_next.mag == '0);
    end

    // carry out of the 64-bit sum means exactly 2^64, root 2^32
    assign len_next = sq_top_reg[NUM_SQ-1] ? {1'b1, 32'd0}
                                           : {1'b0, sq_st_reg[NUM_SQ-1].root};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg   <= {comp_w, comp_z, comp_y, comp_x};
            u4_reg  <= use_fourth_reg;

            sd1_reg <= sd1_next;
            for (int i = 0; i < 4; i++)
                sq_reg[i] <= sd1_next.mag[i] * sd1_next.mag[i];

            sd2_reg <= sd1_reg;
            s01_reg <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]);
            s23_reg <= SUM_W'(sq_reg[2]) + SUM_W'(sq_reg[3]);

            sd3_reg <= sd2_reg;
            sum_reg <= s01_reg + s23_reg;

            sq_st_reg[0]  <= sqrt_step('0, sum_reg[63:62]);
            sq_rad_reg[0] <= {sum_reg[61:0], 2'b00};
            sq_top_reg[0] <= sum_reg[64];
            sq_sd_reg[0]  <= sd3_reg;
            for (int k = 1; k < NUM_SQ; k++)
            begin
                sq_st_reg[k]  <= sqrt_step(sq_st_reg[k-1], sq_rad_reg[k-1][63:62]);
                sq_rad_reg[k] <= {sq_rad_reg[k-1][61:0], 2'b00};
                sq_top_reg[k] <= sq_top_reg[k-1];
                sq_sd_reg[k]  <= sq_sd_reg[k-1];
            end

            // divider: numerator is mag << 30; top 31 bits preload remainder
            for (int i = 0; i < 4; i++)
            begin
                {dv_q_reg[0][i][0], dv_rem_reg[0][i]} <= div_step(
                    {2'b00, sq_sd_reg[NUM_SQ-1].mag[i][31:1]},
                    sq_sd_reg[NUM_SQ-1].mag[i][0], len_next);
                dv_q_reg[0][i][QUO_W-1:1] <= '0;
            end
            dv_den_reg[0] <= len_next;
            dv_sd_reg[0]  <= sq_sd_reg[NUM_SQ-1];
            for (int j = 1; j < NUM_DV; j++)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    {dv_q_reg[j][i][0], dv_rem_reg[j][i]} <= div_step(
                        dv_rem_reg[j-1][i], 1'b0, dv_den_reg[j-1]);
                    dv_q_reg[j][i][QUO_W-1:1] <= dv_q_reg[j-1][i][QUO_W-2:0];
                end
                dv_den_reg[j] <= dv_den_reg[j-1];
                dv_sd_reg[j]  <= dv_sd_reg[j-1];
            end

            for (int i = 0; i < 4; i++)
            begin
                if (dv_sd_reg[NUM_DV-1].zero)
                    u_reg[i] <= '0;
                else if (dv_sd_reg[NUM_DV-1].neg[i])
                    u_reg[i] <= -{1'b0, dv_q_reg[NUM_DV-1][i]};
                else
                    u_reg[i] <= {1'b0, dv_q_reg[NUM_DV-1][i]};
            end
            len_reg  <= dv_sd_reg[NUM_DV-1].zero ? '0 : dv_den_reg[NUM_DV-1];
            zero_reg <= dv_sd_reg[NUM_DV-1].zero;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/vn_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Port-level checker for vector_normalize_unit, bound to the top level.
// Depends on vector_normalize_unit ports only.
module vn_chk
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] unit_x,
    input wire logic [32:0] length,
    input wire logic        was_zero
);

    // held length stays put and valid stays high while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(length))
        else $error("output word changed under stall");

    // stall at the output must stop intake
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken during output stall");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && was_zero |-> length == 33'd0 && unit_x == 32'd0)
        else $error("zero vector with nonzero result");

    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !was_zero |-> length != 33'd0)
        else $error("nonzero vector with zero length");

endmodule

bind vector_normalize_unit vn_chk u_vn_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .unit_x    (unit_x),
    .length    (length),
    .was_zero  (was_zero)
);
`default_nettype wire

// ===== test/vector_normalize_unit_check.sv =====
`timescale 1ns / 1ps
// Checker for the vector normalize unit: watches the input, output and config
// channels, predicts each unit vector and compares. Standalone, no packages.
module vector_normalize_unit_check (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic signed [31:0] comp_x,
    input  wire logic signed [31:0] comp_y,
    input  wire logic signed [31:0] comp_z,
    input  wire logic signed [31:0] comp_w,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic signed [31:0] unit_x,
    input  wire logic signed [31:0] unit_y,
    input  wire logic signed [31:0] unit_z,
    input  wire logic signed [31:0] unit_w,
    input  wire logic [32:0]        length,
    input  wire logic               was_zero,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic               cfg_data,
    output int                      fail_count,
    output int                      pending,
    output int                      seen
);

    typedef struct packed {
        logic [3:0][31:0] unit;
        logic [32:0]      len;
        logic             zero;
    } unit_vec_t;

    unit_vec_t unit_queue[$];
    logic      four_mode;

    function automatic logic [31:0] root64(input logic [64:0] n);
        logic [31:0] r;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            logic [31:0] t;
            t = r | (32'd1 << b);
            if ({1'b0, 64'(t) * 64'(t)} <= n)
                r = t;
        end
        return r;
    endfunction

    function automatic unit_vec_t normalize(input logic [3:0][31:0] c, input logic four);
        unit_vec_t   v;
        logic [64:0] sum;
        logic [63:0] mag;
        logic [63:0] q;
        int          used;
        used = four ? 4 : 3;
        sum = 0;
        v = '0;
        for (int i = 0; i < used; i++)
        begin
            mag = c[i][31] ? 64'(-$signed(c[i])) : 64'(c[i]);
            sum += 65'(mag * mag);
        end
        if (sum == 0)
        begin
            v.zero = 1'b1;
            return v;
        end
        v.len = sum[64] ? 33'h1_0000_0000 : {1'b0, root64(sum)};
        for (int i = 0; i < used; i++)
        begin
            mag = c[i][31] ? 64'(-$signed(c[i])) : 64'(c[i]);
            q = (mag << 30) / 64'(v.len);
            v.unit[i] = c[i][31] ? 32'(-q) : 32'(q);
        end
        return v;
    endfunction

    task automatic report(input string what, input logic [32:0] got, input logic [32:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        unit_vec_t want;
        if (!rst_n)
        begin
            four_mode <= 1'b1;
            unit_queue = {};
            fail_count = 0;
            pending = 0;
            seen = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                unit_queue.push_back(normalize({comp_w, comp_z, comp_y, comp_x}, four_mode));
            if (out_valid && out_ready)
            begin
                seen++;
                if (unit_queue.size() == 0)
                    report("unexpected word", 33'd0, 33'd0);
                else
                begin
                    want = unit_queue.pop_front();
                    if (unit_x !== want.unit[0])
                        report("unit_x", 33'(unit_x), 33'(want.unit[0]));
                    if (unit_y !== want.unit[1])
                        report("unit_y", 33'(unit_y), 33'(want.unit[1]));
                    if (unit_z !== want.unit[2])
                        report("unit_z", 33'(unit_z), 33'(want.unit[2]));
                    if (unit_w !== want.unit[3])
                        report("unit_w", 33'(unit_w), 33'(want.unit[3]));
                    if (length !== want.len)
                        report("length", length, want.len);
                    if (was_zero !== want.zero)
                        report("was_zero", 33'(was_zero), 33'(want.zero));
                end
            end
            pending = unit_queue.size();
            if (cfg_valid && cfg_ready)
                four_mode <= cfg_data;
        end
    end

endmodule

// ===== test/vector_normalize_unit_test.sv =====
`timescale 1ns / 1ps
// Testbench top for the vector normalize unit: drives vectors, config writes
// and output stalls; checking lives in vector_normalize_unit_check.
module vector_normalize_unit_test;

    localparam int LATENCY = 68;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] comp_x, comp_y, comp_z, comp_w;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] unit_x, unit_y, unit_z, unit_w;
    logic [32:0]        length;
    logic               was_zero;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_data;
    int                 fail_count, pending, seen;
    int                 send_idle, recv_idle;   // idle odds in percent
    int                 words_sent;

    vector_normalize_unit dut (.*);

    vector_normalize_unit_check checker_i (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // receiver: random stalls at the current odds
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle);

    // random component biased toward interesting corners
    function automatic logic [31:0] pick_comp();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'd0;
            3: return 32'($signed($urandom_range(131072)) - 65536);
            4: return 32'($signed($urandom_range(511)) - 256);
            default: return $urandom;
        endcase
    endfunction

    // one word on the input channel, with a random gap first; valid stays
    // high after acceptance so the next word can follow without a gap
    task automatic send_vec(input logic [31:0] x, y, z, w);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        comp_x <= x; comp_y <= y; comp_z <= z; comp_w <= w;
        // in_ready is settled between edges
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        words_sent++;
    endtask

    // drain the pipe, then write use_fourth while the unit is empty
    task automatic write_mode(input logic four);
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= four;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            send_vec(pick_comp(), pick_comp(), pick_comp(), pick_comp());
    endtask

    initial
    begin
        rst_n = 0;
        in_valid = 0; cfg_valid = 0; cfg_data = 0;
        comp_x = 0; comp_y = 0; comp_z = 0; comp_w = 0;
        send_idle = 26; recv_idle = 59;
        words_sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed, four-component mode from reset
        send_vec(0, 0, 0, 0);
        send_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_vec(32'h0001_0000, 0, 0, 0);
        send_vec(0, 32'hffff_0000, 0, 0);
        send_vec(0, 0, 0, 1);
        send_vec(32'hffff_ffff, 1, 32'h8000_0000, 32'h7fff_ffff);
        send_vec(3, 4, 0, 0);
        send_vec(0, 0, 0, 32'h8000_0000);
        write_mode(1'b0);
        // three-component mode: w ignored, also in the zero test
        send_vec(0, 0, 0, 32'h1234_5678);
        send_vec(0, 0, 0, 0);
        send_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vec(32'h7fff_ffff, 32'h8000_0000, 1, 32'hffff_ffff);
        send_vec(0, 0, 32'hffff_ffff, 5);
        run_random(130);

        send_idle = 59; recv_idle = 26;
        write_mode(1'b1);
        run_random(130);

        send_idle = 0; recv_idle = 0;
        write_mode(1'b0);
        run_random(60);
        write_mode(1'b1);
        run_random(70);

        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        $display("sent %0d vectors, checked %0d results over both modes and idle mixes",
                 words_sent, seen);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #3ms;
        $display("timeout");
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== vector_normalize_unit.f =====
rtl/vn_pkg.sv
rtl/vector_normalize_unit.sv
rtl/vn_chk.sv
test/vector_normalize_unit_check.sv
test/vector_normalize_unit_test.sv
